// File: src/heightmap_triangle_height_query_defines.svh
// Assertion macros used by the heightmap triangle height query top module.
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define HQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define HQ_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: src/hmtri_pkg.sv
// Package with constants, types and codes for the heightmap triangle height query.
`timescale 1ns / 1ps

package hmtri_pkg;

	// Grid geometry.
	localparam int GRID_CELLS = 128;
	localparam int GRID_SIDE  = GRID_CELLS + 1;
	localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W     = $clog2(GRID_DEPTH);
	localparam int CELL_W     = (GRID_CELLS > 2) ? $clog2(GRID_CELLS) : 1;

	// Fixed point: a cell spans 1024 steps of 1/1024 world unit.
	localparam int FRAC_W   = 10;
	localparam int FRAC_ONE = 1 << FRAC_W;
	localparam int WEIGHT_W = FRAC_W + 1;
	localparam logic [31:0] POS_LIMIT = 32'(GRID_CELLS * FRAC_ONE);

	// Field widths.
	localparam int COORD_W  = 32;
	localparam int INDEX_W  = 8;
	localparam int SAMPLE_W = 8;
	localparam int HEIGHT_W = 18;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(255 * FRAC_ONE);

	// Register indexes of the configuration port.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 1'b1;

	// Item kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Work queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Quad corners in read order.
	localparam int CORNERS = 4;
	localparam logic [1:0] CRN_C0 = 2'd0;
	localparam logic [1:0] CRN_C1 = 2'd1;
	localparam logic [1:0] CRN_C2 = 2'd2;
	localparam logic [1:0] CRN_C3 = 2'd3;

	// One classified item on its way to the back end.
	typedef struct packed {
		logic                is_query;
		logic                on_grid;
		logic [CELL_W-1:0]   cx;
		logic [CELL_W-1:0]   cz;
		logic [FRAC_W-1:0]   fx;
		logic [FRAC_W-1:0]   fz;
		logic                wr_ok;
		logic [INDEX_W-1:0]  row;
		logic [INDEX_W-1:0]  col;
		logic [SAMPLE_W-1:0] sample;
	} hmtri_item_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_DRAIN,
		BK_DONE
	} hmtri_bk_state_t;

endpackage

// File: src/heightmap_triangle_height_query.sv
// An on-grid query makes four corner reads from the grid memory and then drains; a miss goes
// straight to done, where each result waits for the output register to be free. The back
// takes no new item until it is idle again; writes retire one per cycle while it is idle.
// The front takes beats into a 4-entry queue while the back works or a result waits.
// Reset clears control state and both origins; grid heights stay undefined until written.
`timescale 1ns / 1ps

module heightmap_triangle_height_query (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 kind,
	input  logic [hmtri_pkg::INDEX_W-1:0]        grid_row,
	input  logic [hmtri_pkg::INDEX_W-1:0]        grid_col,
	input  logic [hmtri_pkg::SAMPLE_W-1:0]       height_byte,
	input  logic signed [hmtri_pkg::COORD_W-1:0] pos_x,
	input  logic signed [hmtri_pkg::COORD_W-1:0] pos_z,
	output logic                                 empty,
	input  logic                                 pop,
	output logic                                 hit,
	output logic [hmtri_pkg::HEIGHT_W-1:0]       height,
	input  logic                                 cfg_wr_en,
	input  logic [hmtri_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hmtri_pkg::COORD_W-1:0]        cfg_data
);
	import hmtri_pkg::*;

	`include "heightmap_triangle_height_query_defines.svh"

	hmtri_item_t fr_item;
	hmtri_item_t bk_item;
	logic        fr_push;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;

	assign full = q_full;

	// Front end.
	hmtri_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (q_full),
		.kind        (kind),
		.grid_row    (grid_row),
		.grid_col    (grid_col),
		.height_byte (height_byte),
		.pos_x       (pos_x),
		.pos_z       (pos_z),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_push      (fr_push),
		.q_item      (fr_item)
	);

	// Work queue.
	hmtri_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_push),
		.wr_item (fr_item),
		.rd_en   (q_pop),
		.rd_item (bk_item),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	// Back end.
	hmtri_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (bk_item),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.hit     (hit),
		.height  (height)
	);

	// Checks on the decoupling and the result range.
	`HQ_ASSERT_IMPLIES(a_no_push_when_full, q_full, !fr_push, "queue written while full")
	`HQ_ASSERT_IMPLIES(a_no_pop_when_empty, q_pop, !q_empty, "queue read while empty")
	`HQ_ASSERT_IMPLIES(a_miss_is_zero, !empty && !hit, height == '0, "miss with nonzero height")
	`HQ_ASSERT_ALWAYS(a_height_range, empty || (height <= HEIGHT_MAX), "height out of range")

endmodule

// File: src/hmtri_front.sv
// Front end: origin registers, offset, cell and fraction, and item classification.
`timescale 1ns / 1ps

module hmtri_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic                                 full,
	input  logic                                 kind,
	input  logic [hmtri_pkg::INDEX_W-1:0]        grid_row,
	input  logic [hmtri_pkg::INDEX_W-1:0]        grid_col,
	input  logic [hmtri_pkg::SAMPLE_W-1:0]       height_byte,
	input  logic signed [hmtri_pkg::COORD_W-1:0] pos_x,
	input  logic signed [hmtri_pkg::COORD_W-1:0] pos_z,
	input  logic                                 cfg_wr_en,
	input  logic [hmtri_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hmtri_pkg::COORD_W-1:0]        cfg_data,
	output logic                                 q_push,
	output hmtri_pkg::hmtri_item_t               q_item
);
	import hmtri_pkg::*;

	logic [COORD_W-1:0] origin_x_q;
	logic [COORD_W-1:0] origin_z_q;
	logic [COORD_W:0]   rx;
	logic [COORD_W:0]   rz;
	logic               in_x;
	logic               in_z;

	// Chunk origin registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_z_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Z: origin_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Exact signed offsets; a negative offset floors below cell 0 and misses.
	always_comb begin
		rx   = {pos_x[COORD_W-1], pos_x} - {origin_x_q[COORD_W-1], origin_x_q};
		rz   = {pos_z[COORD_W-1], pos_z} - {origin_z_q[COORD_W-1], origin_z_q};
		in_x = !rx[COORD_W] && (rx[COORD_W-1:0] < POS_LIMIT);
		in_z = !rz[COORD_W] && (rz[COORD_W-1:0] < POS_LIMIT);
	end

	// Classify the beat and hand it to the queue.
	always_comb begin
		q_push          = push && !full;
		q_item.is_query = (kind == KIND_QUERY);
		q_item.on_grid  = in_x && in_z;
		q_item.cx       = rx[FRAC_W +: CELL_W];
		q_item.cz       = rz[FRAC_W +: CELL_W];
		q_item.fx       = rx[FRAC_W-1:0];
		q_item.fz       = rz[FRAC_W-1:0];
		q_item.wr_ok    = (int'(grid_row) <= GRID_CELLS) && (int'(grid_col) <= GRID_CELLS);
		q_item.row      = grid_row;
		q_item.col      = grid_col;
		q_item.sample   = height_byte;
	end

endmodule

// File: src/hmtri_queue.sv
// Short work queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module hmtri_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  hmtri_pkg::hmtri_item_t wr_item,
	input  logic                   rd_en,
	output hmtri_pkg::hmtri_item_t rd_item,
	output logic                   q_full,
	output logic                   q_empty
);
	import hmtri_pkg::*;

	hmtri_item_t       slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_item = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// File: src/hmtri_back.sv
// Back end: height grid memory, corner reads, weighted sum and result register.
`timescale 1ns / 1ps

module hmtri_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  hmtri_pkg::hmtri_item_t            q_item,
	output logic                              q_pop,
	output logic                              empty,
	input  logic                              pop,
	output logic                              hit,
	output logic [hmtri_pkg::HEIGHT_W-1:0]    height
);
	import hmtri_pkg::*;

	hmtri_bk_state_t     state_q;
	hmtri_bk_state_t     state_nx;

	logic [SAMPLE_W-1:0] grid_mem [GRID_DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;
	logic [ADDR_W-1:0]   base_q;
	logic [ADDR_W-1:0]   rd_addr;
	logic [ADDR_W-1:0]   wr_addr;
	logic [1:0]          rd_cnt_q;
	logic [1:0]          crn_q;
	logic                rdv_q;
	logic [WEIGHT_W-1:0] weight_q [CORNERS];
	logic [HEIGHT_W-1:0] acc_q;
	logic                res_hit_q;
	logic                out_valid_q;
	logic                out_hit_q;
	logic [HEIGHT_W-1:0] out_height_q;

	logic                mem_we;
	logic                mem_re;
	logic                load_query;
	logic                load_miss;
	logic                load_out;
	logic [WEIGHT_W-1:0] frac_sum;
	logic                upper;
	logic [HEIGHT_W:0]   acc_sum;

	assign empty  = !out_valid_q;
	assign hit    = out_hit_q;
	assign height = out_height_q;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and strobes.
	always_comb begin
		state_nx   = state_q;
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		load_query = 1'b0;
		load_miss  = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (!q_item.is_query) begin
						mem_we = q_item.wr_ok;
					end else if (q_item.on_grid) begin
						load_query = 1'b1;
						state_nx   = BK_READ;
					end else begin
						load_miss = 1'b1;
						state_nx  = BK_DONE;
					end
				end
			end
			BK_READ: begin
				mem_re = 1'b1;
				if (rd_cnt_q == CRN_C3) begin
					state_nx = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				state_nx = BK_DONE;
			end
			BK_DONE: begin
				if (!out_valid_q || pop) begin
					load_out = 1'b1;
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// Corner addresses around the cell base, and the write address.
	always_comb begin
		case (rd_cnt_q)
			CRN_C0:  rd_addr = base_q;
			CRN_C1:  rd_addr = base_q + ADDR_W'(GRID_SIDE);
			CRN_C2:  rd_addr = base_q + ADDR_W'(1);
			CRN_C3:  rd_addr = base_q + ADDR_W'(GRID_SIDE + 1);
			default: rd_addr = base_q;
		endcase
		wr_addr = ADDR_W'(q_item.row) * ADDR_W'(GRID_SIDE) + ADDR_W'(q_item.col);
	end

	// Triangle choice and corner weights; all weights are nonnegative.
	always_comb begin
		frac_sum = WEIGHT_W'(q_item.fx) + WEIGHT_W'(q_item.fz);
		upper    = frac_sum[FRAC_W];
		acc_sum  = (HEIGHT_W + 1)'(acc_q)
			+ (HEIGHT_W + 1)'(rdata_q) * (HEIGHT_W + 1)'(weight_q[crn_q]);
	end

	// Height grid memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[wr_addr] <= q_item.sample;
		end
		if (mem_re) begin
			rdata_q <= grid_mem[rd_addr];
		end
	end

	// Read sequencing control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			rdv_q    <= 1'b0;
			crn_q    <= CRN_C0;
		end else begin
			rdv_q <= mem_re;
			crn_q <= rd_cnt_q;
			if (load_query) begin
				rd_cnt_q <= '0;
			end else if (mem_re) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	// Query datapath: base address, weights and the running sum.
	always_ff @(posedge clk) begin
		if (load_query) begin
			base_q    <= ADDR_W'(q_item.cz) * ADDR_W'(GRID_SIDE) + ADDR_W'(q_item.cx);
			acc_q     <= '0;
			res_hit_q <= 1'b1;
			if (upper) begin
				weight_q[CRN_C0] <= '0;
				weight_q[CRN_C1] <= WEIGHT_W'(FRAC_ONE) - WEIGHT_W'(q_item.fx);
				weight_q[CRN_C2] <= WEIGHT_W'(FRAC_ONE) - WEIGHT_W'(q_item.fz);
				weight_q[CRN_C3] <= frac_sum - WEIGHT_W'(FRAC_ONE);
			end else begin
				weight_q[CRN_C0] <= WEIGHT_W'(FRAC_ONE) - frac_sum;
				weight_q[CRN_C1] <= WEIGHT_W'(q_item.fz);
				weight_q[CRN_C2] <= WEIGHT_W'(q_item.fx);
				weight_q[CRN_C3] <= '0;
			end
		end else if (load_miss) begin
			acc_q     <= '0;
			res_hit_q <= 1'b0;
		end else if (rdv_q) begin
			acc_q <= acc_sum[HEIGHT_W-1:0];
		end
	end

	// Result register toward the output side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_hit_q    <= res_hit_q;
			out_height_q <= acc_q;
		end
	end

endmodule
